/* design/aom_pkg.sv */
`default_nettype none
package aom_pkg;

  localparam int BookDepthDef = 32;

  typedef enum logic [1:0] {
    KIND_FILL   = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_ACCEPT = 2'd2,
    KIND_REJECT = 2'd3
  } kind_t;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_MATCH = 1'b1;
  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic        side;
    logic [31:0] order_id;
    logic [31:0] order_price;
    logic [31:0] order_qty;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] buy_id;
    logic [31:0] sell_id;
    logic [31:0] fill_qty;
    logic [31:0] fill_price;
    logic [31:0] left_qty;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_SCAN,
    ST_FILL,
    ST_DONE,
    ST_PACK,
    ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input item
    logic do_add;     // rest order / build add record
    logic scan_clr;   // start a best-price scan
    logic scan_step;  // examine one slot
    logic do_fill;    // trade against best, build fill record
    logic do_done;    // build done record
    logic pack_clr;   // start compaction
    logic pack_step;  // move one slot
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_match;
    logic scan_end;   // last slot examined this cycle
    logic can_fill;   // best found, within limit, qty left
    logic pack_end;   // last slot moved this cycle
  } dp_stat_t;

endpackage
`default_nettype wire

/* design/aggressor_order_matcher.sv */
`default_nettype none
// Add: the item is loaded, then the ADD state builds the registered accept or reject record.
// Match: each fill costs a best-price scan of every book slot plus the fill and its
// handshake; the walk ends with a last scan, a compaction pass and the done record.
// Scans and compaction read the book through one registered read per cycle;
// one item at a time.
// Synchronous active-low reset empties both books and clears the controller.
module aggressor_order_matcher
  import aom_pkg::*;
#(
  parameter int BOOK_DEPTH = BookDepthDef
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  aom_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .rec_last (out_data.last),
    .cmd      (cmd),
    .stat     (stat)
  );

  aom_dp #(.BOOK_DEPTH(BOOK_DEPTH)) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_data),
    .cmd     (cmd),
    .stat    (stat),
    .out_item(out_data)
  );

endmodule
`default_nettype wire

/* design/aom_ctrl.sv */
`default_nettype none
module aom_ctrl
  import aom_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire logic     rec_last,
  output dp_cmd_t       cmd,
  input  wire dp_stat_t stat
);

  state_t state_r, state_nxt;
  state_t ret_r, ret_nxt;
  logic   ovalid_r, ovalid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ret_r    <= ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_valid = ovalid_r;

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    ovalid_nxt = ovalid_r;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        // accept a new item once the previous final record is taken
        in_ready = !ovalid_r || out_ready;
        if (ovalid_r && out_ready) ovalid_nxt = 1'b0;
        if (in_valid && in_ready) begin
          cmd.load  = 1'b1;
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        if (stat.is_match) begin
          cmd.scan_clr = 1'b1;
          state_nxt    = ST_SCAN;
        end else begin
          cmd.do_add = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_end) state_nxt = ST_FILL;
      end
      ST_FILL: begin
        if (stat.can_fill) begin
          cmd.do_fill = 1'b1;
          ovalid_nxt  = 1'b1;
          ret_nxt     = ST_SCAN;
          state_nxt   = ST_EMIT;
        end else begin
          cmd.pack_clr = 1'b1;
          state_nxt    = ST_PACK;
        end
      end
      ST_PACK: begin
        cmd.pack_step = 1'b1;
        if (stat.pack_end) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        cmd.do_done = 1'b1;
        ovalid_nxt  = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_EMIT: begin
        // a fill record waits here; the next scan starts once it is taken
        if (out_ready) begin
          ovalid_nxt   = 1'b0;
          cmd.scan_clr = 1'b1;
          state_nxt    = ret_r;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // a record marked last is never emitted from the fill wait
  a_emit_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (ovalid_r && !rec_last))
    else $error("fill record marked last");
  // no input accepted mid-walk
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (state_r == ST_IDLE))
    else $error("ready outside idle");
  // a record shown stays until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !out_ready) |=> ovalid_r)
    else $error("record dropped");

endmodule
`default_nettype wire

/* design/aom_dp.sv */
`default_nettype none
module aom_dp
  import aom_pkg::*;
#(
  parameter int BOOK_DEPTH = BookDepthDef
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire in_item_t in_item,
  input  wire dp_cmd_t  cmd,
  output dp_stat_t      stat,
  output out_item_t     out_item
);

  localparam int IW = $clog2(BOOK_DEPTH);
  localparam int CW = $clog2(BOOK_DEPTH + 1);

  // books: index 0 bids, 1 asks; entries kept in arrival order
  logic [31:0] px_r  [2][BOOK_DEPTH];
  logic [31:0] qt_r  [2][BOOK_DEPTH];
  logic [31:0] id_r  [2][BOOK_DEPTH];
  logic [CW-1:0] cnt_r [2];

  in_item_t    item_r;
  logic [31:0] left_r;
  out_item_t   rec_r;

  // read pointer and registered read stage
  logic [IW-1:0] ri_r;      // slot being read
  logic          rd_go_r;   // slots remain to be read
  logic          rd_ok_r;   // read stage holds a slot
  logic [IW-1:0] rd_slot_r;
  logic [31:0]   rd_px_r, rd_qt_r, rd_id_r;

  // compaction write side
  logic [IW-1:0] wi_r;      // write slot
  logic [CW-1:0] wcnt_r;

  // best entry of the current scan
  logic          bfound_r;
  logic [IW-1:0] bidx_r;
  logic [31:0]   bpx_r, bqt_r, bident_r;

  logic          bk;       // book walked or added to
  assign bk = item_r.cmd == CMD_MATCH ? ~item_r.side : item_r.side;

  logic          buy_aggr;
  assign buy_aggr = item_r.side == SIDE_BUY;

  logic          step;
  assign step = cmd.scan_step || cmd.pack_step;

  // read stage holds the final slot
  logic rd_last;
  assign rd_last = rd_ok_r && (rd_slot_r == IW'(BOOK_DEPTH - 1));

  // read stage holds a live entry
  logic rd_live;
  assign rd_live = rd_ok_r && (CW'(rd_slot_r) < cnt_r[bk]) && (rd_qt_r != '0);

  logic better;
  always_comb begin
    if (!bfound_r)     better = 1'b1;
    else if (buy_aggr) better = rd_px_r < bpx_r;
    else               better = rd_px_r > bpx_r;
  end

  logic in_limit;
  assign in_limit = buy_aggr ? (bpx_r <= item_r.order_price)
                             : (bpx_r >= item_r.order_price);

  logic [31:0] mq;
  assign mq = left_r < bqt_r ? left_r : bqt_r;

  assign stat.is_match = item_r.cmd == CMD_MATCH;
  assign stat.scan_end = rd_last;
  assign stat.can_fill = bfound_r && in_limit && (left_r != '0);
  assign stat.pack_end = rd_last;
  assign out_item      = rec_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r[0]  <= '0;
      cnt_r[1]  <= '0;
      ri_r      <= '0;
      rd_go_r   <= 1'b0;
      rd_ok_r   <= 1'b0;
      rd_slot_r <= '0;
      wi_r      <= '0;
      wcnt_r    <= '0;
      bfound_r  <= 1'b0;
    end else begin
      if (cmd.do_add && cnt_r[bk] != CW'(BOOK_DEPTH) && item_r.order_qty != '0)
        cnt_r[bk] <= cnt_r[bk] + 1'b1;
      if (cmd.pack_step && rd_last)
        cnt_r[bk] <= wcnt_r + CW'(rd_live);
      if (cmd.scan_clr || cmd.pack_clr) begin
        ri_r     <= '0;
        rd_go_r  <= 1'b1;
        rd_ok_r  <= 1'b0;
        wi_r     <= '0;
        wcnt_r   <= '0;
        bfound_r <= 1'b0;
      end
      // one slot read per step, evaluated in the next step
      if (step) begin
        rd_ok_r   <= rd_go_r;
        rd_slot_r <= ri_r;
        if (rd_go_r) begin
          if (ri_r == IW'(BOOK_DEPTH - 1)) rd_go_r <= 1'b0;
          else                             ri_r    <= ri_r + 1'b1;
        end
      end
      if (cmd.scan_step && rd_live && better) bfound_r <= 1'b1;
      if (cmd.pack_step && rd_live) begin
        wi_r   <= wi_r + 1'b1;
        wcnt_r <= wcnt_r + 1'b1;
      end
    end
  end

  // datapath registers and book storage
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
      left_r <= in_item.order_qty;
    end
    // registered book read
    if (step) begin
      rd_px_r <= px_r[bk][ri_r];
      rd_qt_r <= qt_r[bk][ri_r];
      rd_id_r <= id_r[bk][ri_r];
    end
    if (cmd.scan_step && rd_live && better) begin
      bidx_r   <= rd_slot_r;
      bpx_r    <= rd_px_r;
      bqt_r    <= rd_qt_r;
      bident_r <= rd_id_r;
    end
    if (cmd.pack_step && rd_live) begin
      px_r[bk][wi_r] <= rd_px_r;
      qt_r[bk][wi_r] <= rd_qt_r;
      id_r[bk][wi_r] <= rd_id_r;
    end
    if (cmd.do_add) begin
      rec_r.buy_id     <= item_r.order_id;
      rec_r.sell_id    <= item_r.order_id;
      rec_r.fill_qty   <= '0;
      rec_r.fill_price <= '0;
      rec_r.left_qty   <= '0;
      rec_r.last       <= 1'b1;
      if (cnt_r[bk] == CW'(BOOK_DEPTH)) begin
        rec_r.kind <= KIND_REJECT;
      end else begin
        rec_r.kind <= KIND_ACCEPT;
        if (item_r.order_qty != '0) begin
          px_r[bk][cnt_r[bk][IW-1:0]] <= item_r.order_price;
          qt_r[bk][cnt_r[bk][IW-1:0]] <= item_r.order_qty;
          id_r[bk][cnt_r[bk][IW-1:0]] <= item_r.order_id;
        end
      end
    end
    if (cmd.do_fill) begin
      qt_r[bk][bidx_r] <= bqt_r - mq;
      left_r           <= left_r - mq;
      rec_r.kind       <= KIND_FILL;
      rec_r.buy_id     <= buy_aggr ? item_r.order_id : bident_r;
      rec_r.sell_id    <= buy_aggr ? bident_r : item_r.order_id;
      rec_r.fill_qty   <= mq;
      rec_r.fill_price <= bpx_r;
      rec_r.left_qty   <= left_r - mq;
      rec_r.last       <= 1'b0;
    end
    if (cmd.do_done) begin
      rec_r.kind       <= KIND_DONE;
      rec_r.buy_id     <= item_r.order_id;
      rec_r.sell_id    <= item_r.order_id;
      rec_r.fill_qty   <= '0;
      rec_r.fill_price <= '0;
      rec_r.left_qty   <= left_r;
      rec_r.last       <= 1'b1;
    end
  end

  // compaction never writes ahead of the slot being moved
  a_pack_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pack_step && rd_live) |-> (wi_r <= rd_slot_r))
    else $error("compaction overrun");
  // book counts stay within depth
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r[0] <= CW'(BOOK_DEPTH)) && (cnt_r[1] <= CW'(BOOK_DEPTH)))
    else $error("count overflow");
  // a fill never exceeds the aggressor's remainder
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_fill |-> (mq <= left_r) && (mq != '0))
    else $error("bad fill size");

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_top
  import aom_pkg::*;
;

  localparam int Depth = BookDepthDef;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  aggressor_order_matcher uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // predicted book: arrival order in slots 0..count-1
  logic [31:0] bid_px[Depth], bid_qt[Depth], bid_oid[Depth];
  logic [31:0] ask_px[Depth], ask_qt[Depth], ask_oid[Depth];
  int          bid_cnt, ask_cnt;

  out_item_t   pending_records[$];
  int          mismatch_count;
  bit          idle_free;      // no random idling while set
  bit          hold_off_req;   // receiver long stall request

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic out_item_t make_rec(kind_t k, logic [31:0] b, logic [31:0] s,
                                         logic [31:0] fq, logic [31:0] fp,
                                         logic [31:0] lq, logic lst);
    out_item_t r;
    r.kind = k; r.buy_id = b; r.sell_id = s; r.fill_qty = fq;
    r.fill_price = fp; r.left_qty = lq; r.last = lst;
    return r;
  endfunction

  // append one expected record
  function automatic void queue_rec(out_item_t r);
    pending_records.insert(pending_records.size(), r);
  endfunction

  // compute the records one order causes and update the predicted book
  task automatic predict_order(in_item_t it);
    int          best;
    logic [31:0] left, m, w;
    bit          buy_aggr;
    if (it.cmd == CMD_MATCH) begin
      buy_aggr = (it.side == SIDE_BUY);
      left = it.order_qty;
      while (left != 0) begin
        best = -1;
        for (int i = 0; i < (buy_aggr ? ask_cnt : bid_cnt); i++) begin
          if (buy_aggr) begin
            if (ask_qt[i] != 0 && (best < 0 || ask_px[i] < ask_px[best])) best = i;
          end else begin
            if (bid_qt[i] != 0 && (best < 0 || bid_px[i] > bid_px[best])) best = i;
          end
        end
        if (best < 0) break;
        if (buy_aggr) begin
          if (ask_px[best] > it.order_price) break;
          m = (left < ask_qt[best]) ? left : ask_qt[best];
          left -= m; ask_qt[best] -= m;
          queue_rec(make_rec(KIND_FILL, it.order_id, ask_oid[best], m,
                             ask_px[best], left, 1'b0));
        end else begin
          if (bid_px[best] < it.order_price) break;
          m = (left < bid_qt[best]) ? left : bid_qt[best];
          left -= m; bid_qt[best] -= m;
          queue_rec(make_rec(KIND_FILL, bid_oid[best], it.order_id, m,
                             bid_px[best], left, 1'b0));
        end
      end
      // squeeze out emptied entries
      w = 0;
      if (buy_aggr) begin
        for (int i = 0; i < ask_cnt; i++)
          if (ask_qt[i] != 0) begin
            ask_px[w] = ask_px[i]; ask_qt[w] = ask_qt[i]; ask_oid[w] = ask_oid[i]; w++;
          end
        ask_cnt = w;
      end else begin
        for (int i = 0; i < bid_cnt; i++)
          if (bid_qt[i] != 0) begin
            bid_px[w] = bid_px[i]; bid_qt[w] = bid_qt[i]; bid_oid[w] = bid_oid[i]; w++;
          end
        bid_cnt = w;
      end
      queue_rec(make_rec(KIND_DONE, it.order_id, it.order_id, 0, 0, left, 1'b1));
    end else if (it.side == SIDE_BUY) begin
      if (bid_cnt >= Depth) begin
        queue_rec(make_rec(KIND_REJECT, it.order_id, it.order_id, 0, 0, 0, 1'b1));
      end else begin
        if (it.order_qty != 0) begin
          bid_px[bid_cnt] = it.order_price; bid_qt[bid_cnt] = it.order_qty;
          bid_oid[bid_cnt] = it.order_id; bid_cnt++;
        end
        queue_rec(make_rec(KIND_ACCEPT, it.order_id, it.order_id, 0, 0, 0, 1'b1));
      end
    end else begin
      if (ask_cnt >= Depth) begin
        queue_rec(make_rec(KIND_REJECT, it.order_id, it.order_id, 0, 0, 0, 1'b1));
      end else begin
        if (it.order_qty != 0) begin
          ask_px[ask_cnt] = it.order_price; ask_qt[ask_cnt] = it.order_qty;
          ask_oid[ask_cnt] = it.order_id; ask_cnt++;
        end
        queue_rec(make_rec(KIND_ACCEPT, it.order_id, it.order_id, 0, 0, 0, 1'b1));
      end
    end
  endtask

  // send one order; prediction happens at acceptance
  // valid stays high after acceptance until the next idle cycle or item
  task automatic send_order(logic c, logic s, logic [31:0] id, logic [31:0] px,
                            logic [31:0] q);
    in_item_t it;
    it.cmd = c; it.side = s; it.order_id = id; it.order_price = px; it.order_qty = q;
    while (!idle_free && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    predict_order(it);
  endtask

  function automatic logic [31:0] rand_word();
    return $urandom();
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        for (int n = 0; n < 400; n++) @(posedge clk);
        hold_off_req = 1'b0;
      end
      out_ready <= idle_free ? 1'b1 : ($urandom_range(99) >= 20);
    end
  end

  // result checker
  initial begin
    out_item_t exp_rec;
    mismatch_count = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_records.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected record %p", out_data);
        end else begin
          exp_rec = pending_records.pop_front();
          if (out_data !== exp_rec) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("record mismatch: expected %p actual %p", exp_rec, out_data);
          end
        end
      end
    end
  end

  task automatic test_adds_and_extremes();
    send_order(CMD_ADD, SIDE_SELL, 32'h0000_0001, 32'd100, 32'd10);
    send_order(CMD_ADD, SIDE_SELL, 32'hFFFF_FFFF, 32'd100, 32'd5);
    send_order(CMD_ADD, SIDE_SELL, 32'h0000_0003, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_order(CMD_ADD, SIDE_SELL, 32'h0000_0004, 32'd90, 32'd0);   // zero qty add
    send_order(CMD_ADD, SIDE_BUY, 32'h0000_0000, 32'd0, 32'd7);
    send_order(CMD_ADD, SIDE_BUY, 32'h0000_0006, 32'd50, 32'd1);
    send_order(CMD_ADD, SIDE_BUY, 32'h0000_0007, 32'd50, 32'd2);
  endtask

  task automatic test_matches();
    send_order(CMD_MATCH, SIDE_BUY, 32'h10, 32'd100, 32'd0);        // zero aggressor
    send_order(CMD_MATCH, SIDE_BUY, 32'h11, 32'd99, 32'd5);         // no cross
    send_order(CMD_MATCH, SIDE_BUY, 32'h12, 32'd100, 32'd12);       // equal prices, time order
    send_order(CMD_MATCH, SIDE_SELL, 32'h13, 32'd0, 32'd4);         // walks bids
    send_order(CMD_MATCH, SIDE_SELL, 32'h14, 32'd0, 32'hFFFF_FFFF); // sweeps all
    send_order(CMD_MATCH, SIDE_BUY, 32'h15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // fill a book to the limit, reject, then sweep with a deep aggressor
  task automatic test_full_book();
    for (int i = 0; i < Depth; i++)
      send_order(CMD_ADD, SIDE_BUY, 32'h100 + i, $urandom_range(20, 1), $urandom_range(9, 1));
    send_order(CMD_ADD, SIDE_BUY, 32'h1FF, 32'd5, 32'd5);
    send_order(CMD_MATCH, SIDE_SELL, 32'h200, 32'd0, 32'hFFFF_FFFF);
  endtask

  // receiver stalls long while the sender keeps offering
  task automatic test_backpressure();
    hold_off_req = 1'b1;
    for (int i = 0; i < 6; i++) send_order(CMD_ADD, SIDE_SELL, 32'h300 + i, 32'd40, 32'd3);
    send_order(CMD_MATCH, SIDE_BUY, 32'h310, 32'd40, 32'd20);
  endtask

  task automatic test_random(int count);
    logic c, s;
    logic [31:0] px, q;
    for (int i = 0; i < count; i++) begin
      idle_free = (i >= count / 3 && i < count / 2);
      c = ($urandom_range(99) < 35);
      s = 1'($urandom_range(1));
      if ($urandom_range(19) == 0) begin
        px = rand_word(); q = rand_word();
      end else begin
        px = $urandom_range(60, 40);
        q  = ($urandom_range(29) == 0) ? 32'd0 : $urandom_range(c ? 40 : 15, 1);
      end
      send_order(c, s, rand_word(), px, q);
    end
    idle_free = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0;
    idle_free = 1'b0; hold_off_req = 1'b0;
    bid_cnt = 0; ask_cnt = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_adds_and_extremes();
    test_matches();
    test_full_book();
    test_backpressure();
    test_random(70);
    in_valid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (3 * (Depth + 1)) @(posedge clk);
    if (mismatch_count == 0 && pending_records.size() == 0)
      $display("aggressor_order_matcher verification clean");
    else
      $display("aggressor_order_matcher verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("aggressor_order_matcher verification failed");
    $finish;
  end

endmodule
`default_nettype wire
